[hdl/stwq_pkg.sv]
// package: shared types and codes for the sorted timeout wait queue
`timescale 1ns / 1ps
package stwq_pkg;

  // opcodes of an input request
  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP      = 2'd1,
    OP_WAKE_EXP = 2'd2,
    OP_WAKE_ALL = 2'd3
  } op_e;

  // result kinds
  typedef enum logic [2:0] {
    KIND_RELEASED  = 3'd0,
    KIND_POPPED    = 3'd1,
    KIND_POP_EMPTY = 3'd2,
    KIND_PUSH_OK   = 3'd3,
    KIND_PUSH_FULL = 3'd4,
    KIND_NONE      = 3'd5
  } kind_e;

  localparam int unsigned KindBits  = 3;
  localparam int unsigned CountBits = 6;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture input request
    logic insert;  // shift-insert captured entry
    logic drop;    // remove head entry
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic head_due;  // head deadline at or before captured time
    logic more;      // a second entry stands behind the head
    logic next_due;  // second entry deadline at or before captured time
  } status_t;

endpackage

[hdl/stwq_if.sv]
// interfaces: request and result channels
`timescale 1ns / 1ps
interface stwq_req_if #(
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned TIME_BITS    = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic [TASK_ID_BITS-1:0] task_id;
  logic [TIME_BITS-1:0]    wake_time;
  logic [TIME_BITS-1:0]    current_time;

  modport source (output valid, opcode, task_id, wake_time, current_time, input ready);
  modport sink (input valid, opcode, task_id, wake_time, current_time, output ready);
endinterface

interface stwq_rsp_if #(
  parameter int unsigned TASK_ID_BITS = 8
);
  logic                    valid;
  logic                    ready;
  logic [2:0]              kind;
  logic [TASK_ID_BITS-1:0] out_task;
  logic                    timed_out;
  logic [5:0]              released_count;
  logic                    last;

  modport source (output valid, kind, out_task, timed_out, released_count, last,
                  input ready);
  modport sink (input valid, kind, out_task, timed_out, released_count, last,
                output ready);
endinterface

[hdl/stwq_datapath.sv]
// datapath: cell chain of sorted entries with shift insert and head drop
`timescale 1ns / 1ps
module stwq_datapath #(
  parameter int unsigned QUEUE_DEPTH  = 32,
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  stwq_pkg::cmd_t          cmd_i,
  input  logic [TASK_ID_BITS-1:0] task_id_i,
  input  logic [TIME_BITS-1:0]    wake_time_i,
  input  logic [TIME_BITS-1:0]    current_time_i,
  output stwq_pkg::status_t       status_o,
  output logic [TASK_ID_BITS-1:0] head_task_o
);
  import stwq_pkg::*;

  localparam int unsigned OccBits = $clog2(QUEUE_DEPTH + 1);

  logic [TIME_BITS-1:0]    dl_q   [QUEUE_DEPTH];
  logic [TASK_ID_BITS-1:0] tk_q   [QUEUE_DEPTH];
  logic [OccBits-1:0]      occ_q, occ_d;
  logic [TASK_ID_BITS-1:0] new_task_q;
  logic [TIME_BITS-1:0]    new_dl_q, now_q;
  logic [QUEUE_DEPTH-1:0]  later;   // entry strictly later than new deadline

  // per-cell compare, only cells in use count
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      later[i] = (OccBits'(i) < occ_q) && (dl_q[i] > new_dl_q);
    end
  end

  // captured request fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      new_task_q <= task_id_i;
      new_dl_q   <= wake_time_i;
      now_q      <= current_time_i;
    end
  end

  // cells: each looks only at its two neighbors and the captured entry
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (cmd_i.insert) begin
        if (later[i]) begin
          if (i == 0) begin
            dl_q[i] <= new_dl_q;
            tk_q[i] <= new_task_q;
          end else if (!later[(i == 0) ? 0 : i-1]) begin
            dl_q[i] <= new_dl_q;
            tk_q[i] <= new_task_q;
          end else begin
            dl_q[i] <= dl_q[(i == 0) ? 0 : i-1];
            tk_q[i] <= tk_q[(i == 0) ? 0 : i-1];
          end
        end else if (OccBits'(i) == occ_q) begin
          if (i == 0 || !later[(i == 0) ? 0 : i-1]) begin
            dl_q[i] <= new_dl_q;
            tk_q[i] <= new_task_q;
          end else begin
            dl_q[i] <= dl_q[(i == 0) ? 0 : i-1];
            tk_q[i] <= tk_q[(i == 0) ? 0 : i-1];
          end
        end
      end else if (cmd_i.drop && i < QUEUE_DEPTH - 1) begin
        dl_q[i] <= dl_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        tk_q[i] <= tk_q[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end
  end

  // fill count
  always_comb begin
    occ_d = occ_q;
    if (cmd_i.insert) begin
      occ_d = occ_q + OccBits'(1);
    end else if (cmd_i.drop) begin
      occ_d = occ_q - OccBits'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  assign status_o.empty    = (occ_q == '0);
  assign status_o.full     = (occ_q == OccBits'(QUEUE_DEPTH));
  assign status_o.head_due = (dl_q[0] <= now_q);
  assign status_o.more     = (occ_q > OccBits'(1));
  assign status_o.next_due = (dl_q[1] <= now_q);
  assign head_task_o       = tk_q[0];
endmodule

[hdl/stwq_ctrl.sv]
// controller: sequences requests and builds result requests
`timescale 1ns / 1ps
module stwq_ctrl #(
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [1:0]              opcode_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [2:0]              kind_o,
  output logic [TASK_ID_BITS-1:0] out_task_o,
  output logic                    timed_out_o,
  output logic [5:0]              released_count_o,
  output logic                    last_o,
  output stwq_pkg::cmd_t          cmd_o,
  input  stwq_pkg::status_t       status_i,
  input  logic [TASK_ID_BITS-1:0] head_task_i
);
  import stwq_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StExec = 2'd1;
  localparam logic [1:0] StWake = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [1:0]              op_q;
  logic [5:0]              cnt_q, cnt_d;
  logic                    ov_q, ov_d;
  logic [2:0]              kind_q, kind_d;
  logic [TASK_ID_BITS-1:0] task_q, task_d;
  logic                    tmo_q, tmo_d;
  logic [5:0]              rc_q, rc_d;
  logic                    last_q, last_d;
  logic                    out_free;
  logic                    in_acc;
  logic                    go;
  logic                    more;

  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle);
  assign in_acc     = in_valid_i && in_ready_o;
  // a wake candidate releases when the head is due or for wake all
  assign go = !status_i.empty && (op_q == OP_WAKE_ALL || status_i.head_due);
  // the entry behind the head releases too when it is due or for wake all
  assign more = status_i.more && (op_q == OP_WAKE_ALL || status_i.next_due);

  // next state and output register
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ov_d    = ov_q && !out_ready_i;
    kind_d  = kind_q;
    task_d  = task_q;
    tmo_d   = tmo_q;
    rc_d    = rc_q;
    last_d  = last_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          cmd_o.load = 1'b1;
          state_d    = StExec;
        end
      end
      StExec: begin
        if (out_free) begin
          ov_d   = 1'b1;
          task_d = '0;
          tmo_d  = 1'b0;
          rc_d   = '0;
          last_d = 1'b1;
          state_d = StIdle;
          case (op_q)
            OP_PUSH: begin
              if (status_i.full) begin
                kind_d = KIND_PUSH_FULL;
              end else begin
                kind_d = KIND_PUSH_OK;
                cmd_o.insert = 1'b1;
              end
            end
            OP_POP: begin
              if (status_i.empty) begin
                kind_d = KIND_POP_EMPTY;
              end else begin
                kind_d = KIND_POPPED;
                task_d = head_task_i;
                cmd_o.drop = 1'b1;
              end
            end
            default: begin
              if (go) begin
                ov_d = 1'b0;
                cnt_d = '0;
                state_d = StWake;
              end else begin
                kind_d = KIND_NONE;
              end
            end
          endcase
        end
      end
      StWake: begin
        // head releases here (due, or wake all); last when the next entry does not follow
        if (out_free) begin
          cmd_o.drop = 1'b1;
          ov_d   = 1'b1;
          kind_d = KIND_RELEASED;
          task_d = head_task_i;
          tmo_d  = (op_q == OP_WAKE_EXP);
          rc_d   = cnt_q + 6'd1;
          cnt_d  = cnt_q + 6'd1;
          last_d = !more;
          if (!more) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q <= opcode_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    task_q <= task_d;
    tmo_q  <= tmo_d;
    rc_q   <= rc_d;
    last_q <= last_d;
  end

  assign out_valid_o      = ov_q;
  assign kind_o           = kind_q;
  assign out_task_o       = task_q;
  assign timed_out_o      = tmo_q;
  assign released_count_o = rc_q;
  assign last_o           = last_q;
endmodule

[hdl/sorted_timeout_wait_queue.sv]
// top level: sorted timeout wait queue
`timescale 1ns / 1ps
// Keeps up to QUEUE_DEPTH tasks sorted by deadline in a chain of register
// cells; equal deadlines keep arrival order. A push or a pop captures the
// request, then inserts or shifts in the cell chain. A wake captures the
// request, then releases tasks from the head, each released task being one
// result; the final result carries last. The result register lets the next
// request in while the final result still waits to be taken.
module sorted_timeout_wait_queue #(
  parameter int unsigned QUEUE_DEPTH  = 32,
  parameter int unsigned TASK_ID_BITS = 8,
  parameter int unsigned TIME_BITS    = 32
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stwq_req_if.sink     req,
  stwq_rsp_if.source   rsp
);
  import stwq_pkg::*;

  cmd_t                    cmd;
  status_t                 status;
  logic [TASK_ID_BITS-1:0] head_task;
  logic                    valid_raw;
  logic                    last_raw;

  stwq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TASK_ID_BITS(TASK_ID_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .task_id_i     (req.task_id),
    .wake_time_i   (req.wake_time),
    .current_time_i(req.current_time),
    .status_o      (status),
    .head_task_o   (head_task)
  );

  stwq_ctrl #(
    .TASK_ID_BITS(TASK_ID_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (req.valid),
    .in_ready_o      (req.ready),
    .opcode_i        (req.opcode),
    .out_valid_o     (valid_raw),
    .out_ready_i     (rsp.ready),
    .kind_o          (rsp.kind),
    .out_task_o      (rsp.out_task),
    .timed_out_o     (rsp.timed_out),
    .released_count_o(rsp.released_count),
    .last_o          (last_raw),
    .cmd_o           (cmd),
    .status_i        (status),
    .head_task_i     (head_task)
  );

  assign rsp.valid = valid_raw;
  assign rsp.last  = last_raw;
endmodule

[hdl/stwq_checker.sv]
// checker: port-level properties of the wait queue
`timescale 1ns / 1ps
module stwq_props (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] kind_i,
  input logic [5:0] released_count_i,
  input logic       last_i
);
  import stwq_pkg::*;

  // single-result kinds always close their request
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != KIND_RELEASED |-> last_i)
    else $error("non-release result without last");

  // released results count from one
  a_rel_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_RELEASED |-> released_count_i != 6'd0)
    else $error("release with zero count");

  // none released carries zero count
  a_none_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == KIND_NONE |-> released_count_i == 6'd0)
    else $error("none released with nonzero count");

  // a stalled result keeps its kind
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(kind_i))
    else $error("stalled result changed");

  // an accepted request closes the input for the next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input open right after a request");
endmodule

bind sorted_timeout_wait_queue stwq_props u_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req.valid),
  .in_ready_i      (req.ready),
  .out_valid_i     (rsp.valid),
  .out_ready_i     (rsp.ready),
  .kind_i          (rsp.kind),
  .released_count_i(rsp.released_count),
  .last_i          (rsp.last)
);
